>>> rtl/template_match_ssd_macros.svh
// Assertion macros for the template matcher back end.
// Depends on nothing; included by files that assert.
`ifndef TEMPLATE_MATCH_SSD_MACROS_SVH
`define TEMPLATE_MATCH_SSD_MACROS_SVH
// Implication checked every cycle outside reset.
`define TMS_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

>>> rtl/tms_pkg.sv
// Shared types and constants of the template matcher.
// Depends on nothing.
package tms_pkg;
   localparam logic [16:0] BEST_RESET = 17'd99999;
   localparam logic [1:0] REG_IMAGE_W = 2'd0;
   localparam logic [1:0] REG_IMAGE_H = 2'd1;
   localparam logic [1:0] REG_TMPL_W  = 2'd2;
   localparam logic [1:0] REG_TMPL_H  = 2'd3;

   // Job handed from the front end to the back end for one window.
   typedef struct packed {
      logic [11:0] left;
      logic [11:0] top;
      logic [11:0] cx;
      logic [11:0] cy;
      logic        last;
   } job_type;
endpackage

>>> rtl/tms_front.sv
// Front end: takes words, keeps template and row line memories, queues windows.
// Depends on tms_pkg.
module tms_front #(
   parameter int MAX_W = 1024,
   parameter int MAX_T = 16,
   parameter int IW_B = 12,
   parameter int TD_B = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [IW_B-1:0]     iw,
   input  logic [IW_B-1:0]     ih,
   input  logic [TD_B-1:0]     tw,
   input  logic [TD_B-1:0]     th,
   input  logic                back_busy,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_action,
   input  logic [7:0]          in_pixel,
   output logic                job_valid,
   input  logic                job_take,
   output tms_pkg::job_type    job,
   input  logic [$clog2(MAX_T*MAX_T)-1:0] t_raddr,
   output logic [7:0]          t_rdata,
   input  logic [$clog2(MAX_T)-1:0] r_rrow,
   input  logic [$clog2(MAX_W)-1:0] r_rcol,
   output logic [7:0]          r_rdata
);
   localparam int TA_B = $clog2(MAX_T*MAX_T);
   localparam int RR_B = $clog2(MAX_T);
   localparam int RC_B = $clog2(MAX_W);
   logic [7:0] tmem [MAX_T*MAX_T];
   logic [7:0] rmem [2**(RR_B+RC_B)];
   logic [2*TD_B-1:0] tcnt_ff, tcnt_in, area;
   logic [IW_B-1:0] col_ff, col_in, row_ff, row_in;
   logic [RR_B-1:0] rrow_ff, rrow_in;
   logic [1:0] qcnt_ff;
   logic qhead_ff;
   tms_pkg::job_type q_ff [2];
   logic acc, win, last, push;
   tms_pkg::job_type nj;

   assign area = tw * th;
   // A word waits while a window is in flight, since it could overwrite template
   // or line data that the back end still reads for that window.
   assign in_ready = (qcnt_ff == 2'd0) && !back_busy && !restart;
   assign acc = in_valid && in_ready;
   assign last = (col_ff == iw - 1'b1) && (row_ff == ih - 1'b1);
   assign win = (col_ff + 1'b1 >= IW_B'(tw)) && (row_ff + 1'b1 >= IW_B'(th));
   assign push = acc && in_action && win;
   assign job_valid = qcnt_ff != 2'd0;
   assign job = q_ff[qhead_ff];

   always_comb begin
      nj.left = col_ff + 1'b1 - IW_B'(tw);
      nj.top  = row_ff + 1'b1 - IW_B'(th);
      nj.cx   = nj.left + IW_B'(tw >> 1);
      nj.cy   = nj.top + IW_B'(th >> 1);
      nj.last = last;
      tcnt_in = tcnt_ff;
      col_in = col_ff;
      row_in = row_ff;
      rrow_in = rrow_ff;
      if (acc && !in_action) begin
         tcnt_in = (tcnt_ff + 1'b1 >= area) ? '0 : tcnt_ff + 1'b1;
      end else if (acc) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            rrow_in = '0;
         end else if (col_ff + 1'b1 >= iw) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
            rrow_in = rrow_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         tcnt_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         rrow_ff <= '0;
      end else begin
         tcnt_ff <= tcnt_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rrow_ff <= rrow_in;
      end
      if (reset) begin
         qcnt_ff <= '0;
         qhead_ff <= 1'b0;
      end else begin
         if (push) q_ff[qhead_ff ^ (qcnt_ff == 2'd1)] <= nj;
         if (job_take) qhead_ff <= !qhead_ff;
         qcnt_ff <= qcnt_ff + {1'b0, push} - {1'b0, job_take};
      end
   end

   // Template and line memories, one write and one registered read each.
   always_ff @(posedge clock) begin
      if (acc && !in_action) tmem[tcnt_ff[TA_B-1:0]] <= in_pixel;
      if (acc && in_action) rmem[{rrow_ff, col_ff[RC_B-1:0]}] <= in_pixel;
      t_rdata <= tmem[t_raddr];
      r_rdata <= rmem[{r_rrow, r_rcol}];
   end
endmodule

>>> rtl/tms_back.sv
// Back end: sums squared differences per window, divides by area, tracks best.
// Depends on tms_pkg.
`include "template_match_ssd_macros.svh"
module tms_back #(
   parameter int MAX_W = 1024,
   parameter int MAX_T = 16,
   parameter int IW_B = 12,
   parameter int TD_B = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [TD_B-1:0]     tw,
   input  logic [TD_B-1:0]     th,
   input  logic                job_valid,
   output logic                job_take,
   input  tms_pkg::job_type    job,
   output logic                busy,
   output logic [$clog2(MAX_T*MAX_T)-1:0] t_raddr,
   input  logic [7:0]          t_rdata,
   output logic [$clog2(MAX_T)-1:0] r_rrow,
   output logic [$clog2(MAX_W)-1:0] r_rcol,
   input  logic [7:0]          r_rdata,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [71:0]         out_data,
   output logic                out_last
);
   localparam int TA_B = $clog2(MAX_T*MAX_T);
   localparam int RR_B = $clog2(MAX_T);
   localparam int RC_B = $clog2(MAX_W);
   localparam int SUM_B = 16 + 2*TD_B;
   typedef enum logic [2:0] {IDLE, READ, ACCUM, DIV, RESULT} state_type;
   state_type state_ff;
   tms_pkg::job_type j_ff;
   logic [TD_B-1:0] x_ff, y_ff;
   logic [TA_B-1:0] ti_ff;
   logic rv_ff;
   logic [SUM_B-1:0] sum_ff, rem_ff;
   logic [16:0] quo_ff;
   logic [4:0] dstep_ff;
   logic [2*TD_B-1:0] area;
   logic [16:0] best_ff;
   logic [IW_B-1:0] bx_ff, by_ff;
   logic [8:0] diff;
   logic [SUM_B:0] trial;

   assign area = tw * th;
   assign diff = {1'b0, r_rdata} - {1'b0, t_rdata};
   assign trial = {rem_ff, quo_ff[16]} - {{(SUM_B+1-2*TD_B){1'b0}}, area};
   assign t_raddr = ti_ff;
   assign r_rrow = RR_B'(j_ff.top + IW_B'(y_ff));
   assign r_rcol = RC_B'(j_ff.left + IW_B'(x_ff));
   assign job_take = (state_ff == IDLE) && job_valid && !restart;
   assign busy = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= IDLE;
         out_valid <= 1'b0;
         rv_ff <= 1'b0;
         best_ff <= tms_pkg::BEST_RESET;
         bx_ff <= '0;
         by_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (job_take) begin
                  j_ff <= job;
                  x_ff <= '0;
                  y_ff <= '0;
                  ti_ff <= '0;
                  sum_ff <= '0;
                  rv_ff <= 1'b0;
                  state_ff <= READ;
               end
            end
            READ: begin
               // One address per cycle; data comes back registered next cycle.
               rv_ff <= 1'b1;
               if (rv_ff) sum_ff <= sum_ff + SUM_B'($signed(diff) * $signed(diff));
               if (x_ff + 1'b1 >= tw) begin
                  x_ff <= '0;
                  if (y_ff + 1'b1 >= th) state_ff <= ACCUM;
                  else y_ff <= y_ff + 1'b1;
               end else begin
                  x_ff <= x_ff + 1'b1;
               end
               ti_ff <= ti_ff + 1'b1;
            end
            ACCUM: begin
               sum_ff <= sum_ff + SUM_B'($signed(diff) * $signed(diff));
               rem_ff <= '0;
               dstep_ff <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               // Restoring division, one quotient bit per cycle.
               if (dstep_ff == 5'd0) begin
                  quo_ff <= sum_ff[16:0];
                  rem_ff <= SUM_B'(sum_ff >> 17);
                  dstep_ff <= 5'd1;
               end else begin
                  if (!trial[SUM_B]) begin
                     rem_ff <= trial[SUM_B-1:0];
                     quo_ff <= {quo_ff[15:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[SUM_B-2:0], quo_ff[16]};
                     quo_ff <= {quo_ff[15:0], 1'b0};
                  end
                  if (dstep_ff == 5'd17) state_ff <= RESULT;
                  dstep_ff <= dstep_ff + 1'b1;
               end
            end
            RESULT: begin
               if (!out_valid) begin
                  out_valid <= 1'b1;
                  out_last <= j_ff.last;
                  out_data[9:0] <= j_ff.cx[9:0];
                  out_data[19:10] <= j_ff.cy[9:0];
                  out_data[35:20] <= quo_ff[15:0];
                  if (quo_ff < best_ff) begin
                     out_data[45:36] <= j_ff.cx[9:0];
                     out_data[55:46] <= j_ff.cy[9:0];
                     out_data[71:56] <= quo_ff[15:0];
                  end else begin
                     out_data[45:36] <= bx_ff[9:0];
                     out_data[55:46] <= by_ff[9:0];
                     out_data[71:56] <= best_ff[15:0];
                  end
                  if (j_ff.last) begin
                     best_ff <= tms_pkg::BEST_RESET;
                     bx_ff <= '0;
                     by_ff <= '0;
                  end else if (quo_ff < best_ff) begin
                     best_ff <= quo_ff;
                     bx_ff <= j_ff.cx;
                     by_ff <= j_ff.cy;
                  end
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
         if (out_valid && out_ready) out_valid <= 1'b0;
      end
   end

   `TMS_ASSERT_IMP(a_take_idle, clock, reset, job_take, state_ff == IDLE)
   `TMS_ASSERT_NEXT(a_div_len, clock, reset, state_ff == ACCUM, state_ff == DIV || restart)
   `TMS_ASSERT_IMP(a_hold, clock, reset, out_valid && !out_ready && state_ff == RESULT, !job_take)
endmodule

>>> rtl/template_match_ssd.sv
// Template matching by sum of squared differences, top level.
// A word that completes a window queues a job; the back end reads the window, sums,
// divides and registers the result on rsp_tvalid. Windows are handled one at a time; other words
// are taken one per cycle while no window is in flight.
// Synchronous active-high reset restores default sizes, counters and the best.
// Depends on tms_pkg, tms_front and tms_back.
module template_match_ssd #(
   parameter int MAX_IMAGE_WIDTH = 1024,
   parameter int MAX_IMAGE_HEIGHT = 1024,
   parameter int MAX_TEMPLATE_DIM = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // center_x, center_y, mean_sq_diff, best_x, best_y, best_value
   output logic        rsp_tlast    // frame_done
);
   localparam int IW_B = 12;
   localparam int TD_B = 7;
   logic [10:0] iw_ff, ih_ff;
   logic [4:0] tw_ff, th_ff;
   logic restart_ff;
   logic [IW_B-1:0] iw, ih;
   logic [TD_B-1:0] tw, th;
   logic job_valid, job_take, back_busy;
   tms_pkg::job_type job;
   logic [$clog2(MAX_TEMPLATE_DIM*MAX_TEMPLATE_DIM)-1:0] t_raddr;
   logic [7:0] t_rdata, r_rdata;
   logic [$clog2(MAX_TEMPLATE_DIM)-1:0] r_rrow;
   logic [$clog2(MAX_IMAGE_WIDTH)-1:0] r_rcol;

   always_comb begin
      iw = (iw_ff == 0) ? IW_B'(1) :
           (iw_ff > MAX_IMAGE_WIDTH) ? IW_B'(MAX_IMAGE_WIDTH) : IW_B'(iw_ff);
      ih = (ih_ff == 0) ? IW_B'(1) :
           (ih_ff > MAX_IMAGE_HEIGHT) ? IW_B'(MAX_IMAGE_HEIGHT) : IW_B'(ih_ff);
      tw = (tw_ff == 0) ? TD_B'(1) :
           (tw_ff > MAX_TEMPLATE_DIM) ? TD_B'(MAX_TEMPLATE_DIM) : TD_B'(tw_ff);
      th = (th_ff == 0) ? TD_B'(1) :
           (th_ff > MAX_TEMPLATE_DIM) ? TD_B'(MAX_TEMPLATE_DIM) : TD_B'(th_ff);
      if (IW_B'(tw) > iw) tw = TD_B'(iw);
      if (IW_B'(th) > ih) th = TD_B'(ih);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= 11'd1024;
         ih_ff <= 11'd1024;
         tw_ff <= 5'd3;
         th_ff <= 5'd3;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               tms_pkg::REG_IMAGE_W: iw_ff <= csr_wdata;
               tms_pkg::REG_IMAGE_H: ih_ff <= csr_wdata;
               tms_pkg::REG_TMPL_W:  tw_ff <= csr_wdata[4:0];
               tms_pkg::REG_TMPL_H:  th_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   tms_front #(.MAX_W(MAX_IMAGE_WIDTH), .MAX_T(MAX_TEMPLATE_DIM),
               .IW_B(IW_B), .TD_B(TD_B)) u_front (
      .clock, .reset, .restart(restart_ff), .iw, .ih, .tw, .th, .back_busy,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_action(req_tuser),
      .in_pixel(req_tdata), .job_valid, .job_take, .job,
      .t_raddr, .t_rdata, .r_rrow, .r_rcol, .r_rdata);

   tms_back #(.MAX_W(MAX_IMAGE_WIDTH), .MAX_T(MAX_TEMPLATE_DIM), .IW_B(IW_B),
              .TD_B(TD_B)) u_back (
      .clock, .reset, .restart(restart_ff), .tw, .th, .job_valid, .job_take, .job,
      .busy(back_busy), .t_raddr, .t_rdata, .r_rrow, .r_rcol, .r_rdata,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata),
      .out_last(rsp_tlast));
endmodule

>>> tb/template_match_ssd_checker.sv
// Checker for the template matcher: follows register writes and accepted words,
// predicts every window result and compares it with the result channel.
// Depends on tms_pkg and the template_match_ssd port list.
`timescale 1ns / 1ps
module template_match_ssd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic        req_tuser,   // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // center_x, center_y, mean_sq_diff, best_x, best_y, best_value
   input  logic        rsp_tlast,   // frame_done
   output int          fail_count,
   output int          pending
);
   localparam int IMG_MAX = 1024;
   localparam int TMPL_MAX = 16;

   typedef struct {
      logic [9:0]  center_x;
      logic [9:0]  center_y;
      logic [15:0] mean_sq_diff;
      logic [9:0]  best_x;
      logic [9:0]  best_y;
      logic [15:0] best_value;
      logic        frame_done;
   } window_result_type;

   window_result_type window_q[$];

   logic [10:0] img_w_reg, img_h_reg;
   logic [4:0]  tmpl_w_reg, tmpl_h_reg;
   logic [7:0]  tmpl_pix[TMPL_MAX*TMPL_MAX];
   logic [7:0]  line_pix[TMPL_MAX][IMG_MAX];
   int          tmpl_pos, col_pos, row_pos;
   logic [16:0] best_score;
   int          best_col, best_row;

   function automatic int clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic restart_frame();
      tmpl_pos = 0;
      col_pos = 0;
      row_pos = 0;
      best_score = tms_pkg::BEST_RESET;
      best_col = 0;
      best_row = 0;
   endtask

   task automatic predict_word(logic action, logic [7:0] pix);
      int iw, ih, tw, th, area, col, row, left, top, sum, diff, mean, cx, cy;
      bit frame_end;
      window_result_type r;
      iw = clamp(img_w_reg, IMG_MAX);
      ih = clamp(img_h_reg, IMG_MAX);
      tw = clamp(tmpl_w_reg, TMPL_MAX);
      th = clamp(tmpl_h_reg, TMPL_MAX);
      if (tw > iw) tw = iw;
      if (th > ih) th = ih;
      area = tw * th;
      if (!action) begin
         if (tmpl_pos >= area) tmpl_pos = 0;
         tmpl_pix[tmpl_pos] = pix;
         tmpl_pos = (tmpl_pos + 1 >= area) ? 0 : tmpl_pos + 1;
         return;
      end
      col = (col_pos >= iw) ? 0 : col_pos;
      row = (row_pos >= ih) ? 0 : row_pos;
      line_pix[row % TMPL_MAX][col] = pix;
      frame_end = (col == iw - 1) && (row == ih - 1);
      if (col + 1 >= tw && row + 1 >= th) begin
         left = col + 1 - tw;
         top = row + 1 - th;
         sum = 0;
         for (int y = 0; y < th; y++)
            for (int x = 0; x < tw; x++) begin
               diff = int'(line_pix[(top + y) % TMPL_MAX][left + x])
                      - int'(tmpl_pix[y*tw + x]);
               sum += diff * diff;
            end
         mean = sum / area;
         cx = left + tw / 2;
         cy = top + th / 2;
         if (mean < best_score) begin
            best_score = 17'(mean);
            best_col = cx;
            best_row = cy;
         end
         r.center_x = 10'(cx);
         r.center_y = 10'(cy);
         r.mean_sq_diff = 16'(mean);
         r.best_x = 10'(best_col);
         r.best_y = 10'(best_row);
         r.best_value = best_score[15:0];
         r.frame_done = frame_end;
         window_q.insert(window_q.size(), r);
      end
      if (frame_end) begin
         col_pos = 0;
         row_pos = 0;
         best_score = tms_pkg::BEST_RESET;
         best_col = 0;
         best_row = 0;
      end else if (col + 1 >= iw) begin
         col_pos = 0;
         row_pos = row + 1;
      end else begin
         col_pos = col + 1;
         row_pos = row;
      end
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      window_result_type e;
      if (reset) begin
         img_w_reg = 1024;
         img_h_reg = 1024;
         tmpl_w_reg = 3;
         tmpl_h_reg = 3;
         restart_frame();
         window_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tms_pkg::REG_IMAGE_W: img_w_reg = csr_wdata;
               tms_pkg::REG_IMAGE_H: img_h_reg = csr_wdata;
               tms_pkg::REG_TMPL_W:  tmpl_w_reg = csr_wdata[4:0];
               tms_pkg::REG_TMPL_H:  tmpl_h_reg = csr_wdata[4:0];
               default: ;
            endcase
            restart_frame();
         end
         if (req_tvalid && req_tready) predict_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (window_q.size() == 0) begin
               $error("result word with no window pending");
               fail_count++;
            end else begin
               e = window_q.pop_front();
               check_field("center_x", e.center_x, rsp_tdata[9:0]);
               check_field("center_y", e.center_y, rsp_tdata[19:10]);
               check_field("mean_sq_diff", e.mean_sq_diff, rsp_tdata[35:20]);
               check_field("best_x", e.best_x, rsp_tdata[45:36]);
               check_field("best_y", e.best_y, rsp_tdata[55:46]);
               check_field("best_value", e.best_value, rsp_tdata[71:56]);
               check_field("frame_done", e.frame_done, rsp_tlast);
            end
         end
      end
      pending = window_q.size();
   end
endmodule

>>> tb/template_match_ssd_tb.sv
// Top of the template matcher testbench: clock, reset, register setup and
// pixel stimulus with bursty sending and stalled receiving.
// Depends on tms_pkg, template_match_ssd and template_match_ssd_checker.
`timescale 1ns / 1ps
module template_match_ssd_tb;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE = 300;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count, pending;
   int          cycles = 0;
   int          burst_left = 0;
   int          pixels_sent = 0;
   logic [7:0]  iw_list[6] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};

   template_match_ssd uut (.*);

   template_match_ssd_checker u_checker (.*);

   initial begin
      clock = 0;
      reset = 1;
      csr_we = 0;
      csr_index = tms_pkg::REG_IMAGE_W;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      rsp_tready = 0;
   end

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[template_match_ssd] ERROR");
         $finish;
      end
   end

   // Receiver alternates between always-ready stretches and random stalls.
   int stall_mode = 0, mode_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(2, 0);
         mode_left = $urandom_range(200, 10);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(3, 0) != 0);
         default: rsp_tready <= ($urandom_range(4, 0) == 0);
      endcase
   end

   function automatic int clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic send_word(logic action, logic [7:0] pix);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(300, 50)
                                                   : $urandom_range(12, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (action) pixels_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(int iw, int ih, int tw, int th);
      int vals[4];
      vals = '{iw, ih, tw, th};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i][10:0];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // One setting: full template load (possibly wrapping), then frames of
   // source pixels with stray template words mixed in.
   task automatic run_setting(int iw_raw, int ih_raw, int tw_raw, int th_raw,
                              int frames, int pix_hi, int noise_pct, bit cut_last);
      int iw, ih, tw, th, n;
      configure(iw_raw, ih_raw, tw_raw, th_raw);
      iw = clamp(iw_raw, 1024);
      ih = clamp(ih_raw, 1024);
      tw = clamp(tw_raw[4:0], 16);
      th = clamp(th_raw[4:0], 16);
      if (tw > iw) tw = iw;
      if (th > ih) th = ih;
      n = tw * th + (($urandom_range(4, 0) == 0) ? $urandom_range(2 * tw * th, 1) : 0);
      repeat (n) send_word(1'b0, 8'($urandom_range(pix_hi, 0)));
      for (int f = 0; f < frames; f++) begin
         n = iw * ih;
         if (cut_last && f == frames - 1) n = $urandom_range(n, 0);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < noise_pct)
               send_word(1'b0, 8'($urandom_range(pix_hi, 0)));
            send_word(1'b1, 8'($urandom_range(pix_hi, 0)));
         end
      end
   endtask

   initial begin
      int iw, ih, tw, th;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme pixel values against a checkered template.
      configure(3, 2, 2, 2);
      send_word(1'b0, 8'd255);
      send_word(1'b0, 8'd0);
      send_word(1'b0, 8'd0);
      send_word(1'b0, 8'd255);
      foreach (iw_list[i]) send_word(1'b1, iw_list[i]);
      // Zero sizes act as one: every source word is a whole frame.
      configure(0, 0, 0, 0);
      send_word(1'b0, 8'd0);
      send_word(1'b1, 8'd255);
      send_word(1'b1, 8'd0);
      // Template larger than the image, loaded past its end so the load wraps.
      configure(2, 1, 31, 31);
      send_word(1'b0, 8'd17);
      send_word(1'b0, 8'd200);
      send_word(1'b0, 8'd128);
      send_word(1'b1, 8'd1);
      send_word(1'b1, 8'd254);

      // Extremes of the sizes.
      run_setting(2047, 1, 2, 1, 1, 255, 2, 0);
      run_setting(1, 40, 1, 4, 1, 255, 2, 0);
      run_setting(17, 17, 16, 16, 1, 255, 0, 0);

      while (pixels_sent < 1900) begin
         iw = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(24, 1);
         ih = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(12, 1);
         tw = ($urandom_range(9, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(6, 1);
         th = ($urandom_range(9, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(5, 1);
         run_setting(iw, ih, tw, th, $urandom_range(3, 1),
                     ($urandom_range(2, 0) == 0) ? 3 : 255,
                     ($urandom_range(1, 0) == 0) ? 0 : 5,
                     ($urandom_range(5, 0) == 0));
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("[template_match_ssd] OK");
      end else begin
         $display("[template_match_ssd] ERROR");
      end
      $finish;
   end
endmodule
